// ===== design/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and codes for the trial division prime test: verdict codes
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tdp_pkg;

   localparam logic [1:0] VERDICT_NEITHER   = 2'd0;
   localparam logic [1:0] VERDICT_PRIME     = 2'd1;
   localparam logic [1:0] VERDICT_COMPOSITE = 2'd2;

   typedef struct packed {
      logic load;
      logic start_div;
      logic div_step;
      logic next_div;
   } tdp_cmd_type;

   typedef struct packed {
      logic below_two;
      logic sq_over;
      logic div_last;
      logic rem_zero;
   } tdp_status_type;

endpackage

// ===== design/tdp_datapath.sv =====
// ----------------------------------------------------------------------------
// tdp_datapath
// Holds the candidate, the trial divisor and its square, and a restoring
// bit-serial remainder unit that takes one candidate bit per cycle.
// ----------------------------------------------------------------------------
module tdp_datapath
   import tdp_pkg::*;
#(
   parameter int NUM_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [NUM_WIDTH-1:0] candidate,
   input  tdp_cmd_type          cmd,
   output tdp_status_type       status
);

   localparam int DW = (NUM_WIDTH + 1) / 2 + 1;
   localparam int SW = 2 * DW;
   localparam int CW = $clog2(NUM_WIDTH);

   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] shift_ff, shift_in;
   logic [DW-1:0]        d_ff, d_in;
   logic [SW-1:0]        sq_ff, sq_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic [DW:0]          trial;
   logic [DW:0]          diff;
   logic                 fits;

   assign trial = {rem_ff, shift_ff[NUM_WIDTH-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      n_in     = n_ff;
      shift_in = shift_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         n_in  = candidate;
         d_in  = DW'(2);
         sq_in = SW'(4);
      end
      if (cmd.start_div) begin
         shift_in = n_ff;
         rem_in   = '0;
         cnt_in   = '0;
      end
      if (cmd.div_step) begin
         shift_in = {shift_ff[NUM_WIDTH-2:0], 1'b0};
         rem_in   = fits ? diff[DW-1:0] : trial[DW-1:0];
         cnt_in   = cnt_ff + CW'(1);
      end
      if (cmd.next_div) begin
         d_in  = d_ff + DW'(1);
         sq_in = sq_ff + {{(SW-DW-1){1'b0}}, d_ff, 1'b0} + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      shift_ff <= shift_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign status.below_two = n_ff < NUM_WIDTH'(2);
   assign status.sq_over   = sq_ff > {{(SW-NUM_WIDTH){1'b0}}, n_ff};
   assign status.div_last  = cnt_ff == CW'(NUM_WIDTH - 1);
   assign status.rem_zero  = rem_ff == '0;

   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> rem_ff < d_ff)
      else $error("remainder not below divisor");

   a_load_first_divisor : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> d_ff == DW'(2) && sq_ff == SW'(4))
      else $error("first divisor or square wrong");

endmodule

// ===== design/tdp_controller.sv =====
// ----------------------------------------------------------------------------
// tdp_controller
// Sequences the trials: bound check, bit-serial remainder, divisor advance,
// and holds the verdict until the result side takes it.
// ----------------------------------------------------------------------------
module tdp_controller
   import tdp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [1:0]     rsp_verdict,
   output tdp_cmd_type    cmd,
   input  tdp_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] verdict_ff, verdict_in;

   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.below_two) begin
               verdict_in = VERDICT_NEITHER;
               state_in   = ST_OUT;
            end else if (status.sq_over) begin
               verdict_in = VERDICT_PRIME;
               state_in   = ST_OUT;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.rem_zero) begin
               verdict_in = VERDICT_COMPOSITE;
               state_in   = ST_OUT;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      verdict_ff <= verdict_in;
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = state_ff == ST_OUT;
   assign rsp_verdict = verdict_ff;

   a_no_accept_while_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   a_verdict_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> verdict_ff == VERDICT_NEITHER || verdict_ff == VERDICT_PRIME ||
                    verdict_ff == VERDICT_COMPOSITE)
      else $error("illegal verdict code");

   a_composite_needs_zero_rem : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && status.rem_zero |=> verdict_ff == VERDICT_COMPOSITE)
      else $error("zero remainder not reported composite");

endmodule

// ===== design/trial_division_prime_test.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Classifies an unsigned number as neither, prime or composite by trial
// division with divisors 2, 3, 4, ... while divisor squared <= number.
// Numbers below 2, or numbers that need no trial, are classified at the bound
// check; every trial divisor runs the bit-serial remainder unit over all
// candidate bits, and a divisor that is found ends the search.
// Throughput: one request at a time; the next request is taken the cycle
// after the result is accepted. Worst case is about 2^(NUM_WIDTH/2) trials.
// Reset: synchronous, returns the controller to idle; no result is pending.
// ----------------------------------------------------------------------------
module trial_division_prime_test
   import tdp_pkg::*;
#(
   parameter int NUM_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NUM_WIDTH-1:0] req_candidate,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_verdict
);

   tdp_cmd_type    cmd;
   tdp_status_type status;

   tdp_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_verdict (rsp_verdict),
      .cmd         (cmd),
      .status      (status)
   );

   tdp_datapath #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .candidate (req_candidate),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== bench/trial_division_prime_test_test.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_test
// Self-checking bench for the trial division prime test. A driver sends
// candidates in bursts and a monitor checks every verdict against an exact
// Miller-Rabin classifier. Candidates are picked so that the smallest divisor
// is small, which keeps each trial loop short.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trial_division_prime_test_test;
   import tdp_pkg::*;

   localparam int NUM_WIDTH      = 64;
   localparam int RESET_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int RANDOM_COUNT   = 75;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [NUM_WIDTH-1:0] req_candidate;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_verdict;

   logic [NUM_WIDTH-1:0] pending_candidates [$];
   logic [1:0]           expected_verdicts [$];
   int unsigned          witness_bases [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

   int                   burst_left;
   int                   gap_left;
   int unsigned          stall_cycle;
   int                   stall_mode;
   int                   idle_cycles;
   int                   error_count;
   int                   requests_sent;
   int                   requests_total;
   int                   verdicts_checked;
   int                   prime_count;
   int                   composite_count;
   int                   neither_count;
   int                   stall_count;

   trial_division_prime_test #(
      .NUM_WIDTH(NUM_WIDTH)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_candidate(req_candidate),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_verdict  (rsp_verdict)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] product;
      logic [127:0] remainder;
      product   = {64'd0, a} * {64'd0, b};
      remainder = product % {64'd0, m};
      return remainder[63:0];
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] base;
      logic [63:0] exponent;
      acc      = 64'd1 % m;
      base     = b % m;
      exponent = e;
      while (exponent != 0) begin
         if (exponent[0])
            acc = mul_mod(acc, base, m);
         base     = mul_mod(base, base, m);
         exponent = exponent >> 1;
      end
      return acc;
   endfunction

   // exact for every 64-bit value of at least two
   function automatic bit is_prime_number(logic [63:0] n);
      logic [63:0] odd_part;
      logic [63:0] x;
      int          twos;
      bit          decided;
      bit          result;
      bit          witness;
      decided = 0;
      result  = 1;
      for (int k = 0; k < 12; k++) begin
         if (!decided && n == witness_bases[k]) begin
            decided = 1;
            result  = 1;
         end else if (!decided && n % witness_bases[k] == 0) begin
            decided = 1;
            result  = 0;
         end
      end
      if (decided)
         return result;
      odd_part = n - 1;
      twos     = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      for (int k = 0; k < 12; k++) begin
         x = pow_mod(witness_bases[k], odd_part, n);
         if (result && x != 1 && x != n - 1) begin
            witness = 1;
            for (int r = 1; r < twos; r++) begin
               x = mul_mod(x, x, n);
               if (x == n - 1)
                  witness = 0;
               if (!witness)
                  break;
            end
            if (witness)
               result = 0;
         end
      end
      return result;
   endfunction

   function automatic logic [1:0] classify_number(logic [NUM_WIDTH-1:0] n);
      if (n < 2)
         return VERDICT_NEITHER;
      else if (is_prime_number(n))
         return VERDICT_PRIME;
      else
         return VERDICT_COMPOSITE;
   endfunction

   // keeps the trial loop short: small value or a divisor of at most 13
   function automatic bit quick_to_test(logic [63:0] n);
      if (n < 64'd65536)
         return 1;
      for (int d = 2; d <= 13; d++)
         if (n % d == 0)
            return 1;
      return 0;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] random_candidate();
      logic [63:0] n;
      logic [63:0] factor;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            n = random_word();
            while (!quick_to_test(n))
               n = random_word();
         end
         3, 4: n = $urandom_range(0, 65535);
         5: n = $urandom_range(0, 255);
         6, 7: begin
            factor = $urandom_range(2, 255);
            n      = factor * $urandom_range(2, 255);
         end
         default: begin
            factor = $urandom_range(2, 255);
            n      = factor * (random_word() >> 8);
         end
      endcase
      return n;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_candidate <= '0;
         burst_left    <= 1;
         gap_left      <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_verdicts.push_back(classify_number(req_candidate));
            requests_sent++;
         end
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_candidates.size() > 0) begin
            req_valid     <= 1'b1;
            req_candidate <= pending_candidates.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 6);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_cycle <= 0;
         stall_mode  <= 0;
      end else begin
         stall_cycle <= stall_cycle + 1;
         if (stall_cycle % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= stall_cycle[3];
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [1:0] expected;
      if (!reset && rsp_valid) begin
         if (rsp_stall) begin
            stall_count++;
         end else if (expected_verdicts.size() == 0) begin
            $error("unexpected result: verdict %0d with no request outstanding", rsp_verdict);
            error_count++;
         end else begin
            expected = expected_verdicts.pop_front();
            verdicts_checked++;
            case (expected)
               VERDICT_PRIME:     prime_count++;
               VERDICT_COMPOSITE: composite_count++;
               default:           neither_count++;
            endcase
            if (rsp_verdict !== expected) begin
               $error("verdict mismatch: expected %0d, actual %0d", expected, rsp_verdict);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] directed [$];
      directed = '{
         64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9,
         64'd25, 64'd49, 64'd121, 64'd63001, 64'd60491, 64'd65521, 64'd65536,
         64'd65537, 64'd65025,
         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000,
         64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
      };
      error_count      = 0;
      requests_sent    = 0;
      verdicts_checked = 0;
      prime_count      = 0;
      composite_count  = 0;
      neither_count    = 0;
      stall_count      = 0;
      idle_cycles      = 0;
      foreach (directed[i])
         pending_candidates.push_back(directed[i]);
      for (int i = 0; i < RANDOM_COUNT; i++)
         pending_candidates.push_back(random_candidate());
      requests_total = pending_candidates.size();

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (requests_sent < requests_total || req_valid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d verdicts: %0d prime, %0d composite, %0d neither",
               verdicts_checked, prime_count, composite_count, neither_count);
      $display("results held under receiver stall on %0d cycles", stall_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
